FILE: src/onnd_pkg.sv
`timescale 1ns / 1ps
package onnd_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NUM_OCT   = 8;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = POS_W + 1;
    localparam int HITS_W  = 8;
    localparam int RAD_W   = 24;
    localparam int SQ_W    = 2 * POS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int NUM_W   = SQ_W + 4;
    localparam int QUO_W   = 46;
    localparam int ROOT_W  = QUO_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int OUT_W   = 28;
    localparam int OCT_W   = 3;
    localparam int CNT_W   = 5;

    localparam int IN_DATA_W  = 4 * POS_W + HITS_W;
    localparam int OUT_DATA_W = NUM_OCT * OUT_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RAD_W;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS = 1'b1;

    localparam logic [RAD_W-1:0]  RADIUS_RST   = 24'd2560;
    localparam logic [HITS_W-1:0] MIN_HITS_RST = 8'd3;
    localparam logic [OUT_W-1:0]  FAR_VAL      = OUT_W'(1000000 << FRAC_BITS);

    // divide by 100: a nibble per step, quotient digit by reciprocal
    localparam int DIV_REM_W = 7;
    localparam int DIV_V_W   = DIV_REM_W + 4;
    localparam int DIV_P_W   = 2 * DIV_V_W;
    localparam int DIV_SHIFT = 17;
    localparam logic [DIV_V_W-1:0] DIV_RECIP = 11'd1311;
    localparam logic [DIV_V_W-1:0] DIV_CONST = 11'd100;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W / 4 - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic sum;
        logic div_init;
        logic div_step;
        logic sqrt_step;
        logic upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic last;
        logic out_free;
    } t_stat;

endpackage

FILE: src/onnd_ctrl.sv
`timescale 1ns / 1ps
module onnd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  onnd_pkg::t_stat  i_stat,
    output onnd_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_DIVL = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]                 r_state, n_state;
    logic [onnd_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DIVL;
            end
            S_DIVL: begin
                if (i_stat.pass) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == onnd_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == onnd_pkg::SQRT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: src/onnd_dpath.sv
`timescale 1ns / 1ps
module onnd_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [onnd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [onnd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [onnd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [onnd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  onnd_pkg::t_cmd                      i_cmd,
    output onnd_pkg::t_stat                     o_stat
);

    localparam int PW = onnd_pkg::POS_W;
    localparam int DW = onnd_pkg::DIFF_W;

    logic [onnd_pkg::RAD_W-1:0]   r_radius;
    logic [onnd_pkg::HITS_W-1:0]  r_min_hits;
    logic [onnd_pkg::OUT_W-1:0]   r_min [onnd_pkg::NUM_OCT];
    logic                         r_out_valid;

    logic [PW-1:0]                r_ref_x, r_ref_y, r_oth_x, r_oth_y;
    logic                         r_consider, r_last;
    logic [PW-1:0]                r_ax, r_ay;
    logic                         r_sx, r_sy;
    logic [onnd_pkg::SQ_W-1:0]    r_sqx, r_sqy, r_r2;
    logic                         r_oct_ok;
    logic [onnd_pkg::OCT_W-1:0]   r_oct;
    logic                         r_pass;
    logic [onnd_pkg::SUM_W-1:0]   r_sum;
    logic [onnd_pkg::NUM_W-1:0]   r_num;
    logic [onnd_pkg::DIV_REM_W-1:0] r_rem;
    logic [onnd_pkg::QUO_W-1:0]   r_quo;
    logic [onnd_pkg::SREM_W-1:0]  r_srem;
    logic [onnd_pkg::ROOT_W-1:0]  r_root;

    logic [DW-1:0]                w_dx, w_dy;
    logic                         w_lt;
    logic [onnd_pkg::OCT_W-1:0]   w_oct;
    logic [onnd_pkg::SUM_W-1:0]   w_sum;
    logic [onnd_pkg::DIV_V_W-1:0] w_dv, w_qm, w_dr;
    logic [onnd_pkg::DIV_P_W-1:0] w_prod;
    logic [3:0]                   w_qd;
    logic [onnd_pkg::SREM_W+1:0]  w_rt, w_trial, w_sub;
    logic                         w_ge;
    logic [onnd_pkg::OUT_W-1:0]   w_scaled, w_cur;

    // offsets, sign-extended
    assign w_dx = {r_oth_x[PW-1], r_oth_x} - {r_ref_x[PW-1], r_ref_x};
    assign w_dy = {r_oth_y[PW-1], r_oth_y} - {r_ref_y[PW-1], r_ref_y};

    // octant index, zero based
    assign w_lt = (r_ax < r_ay);
    always_comb begin
        case ({r_sx, r_sy})
            2'b00:   w_oct = w_lt ? 3'd0 : 3'd1;
            2'b01:   w_oct = w_lt ? 3'd3 : 3'd2;
            2'b11:   w_oct = w_lt ? 3'd4 : 3'd5;
            default: w_oct = w_lt ? 3'd7 : 3'd6;
        endcase
    end

    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // one decimal-remainder long-division step on a nibble
    assign w_dv   = {r_rem, r_num[onnd_pkg::NUM_W-1 -: 4]};
    assign w_prod = {{onnd_pkg::DIV_V_W{1'b0}}, w_dv}
                  * {{onnd_pkg::DIV_V_W{1'b0}}, onnd_pkg::DIV_RECIP};
    assign w_qd   = w_prod[onnd_pkg::DIV_SHIFT+3 : onnd_pkg::DIV_SHIFT];
    assign w_qm   = {{(onnd_pkg::DIV_V_W-4){1'b0}}, w_qd} * onnd_pkg::DIV_CONST;
    assign w_dr   = w_dv - w_qm;

    // restoring square root step
    assign w_rt    = {r_srem, r_quo[onnd_pkg::QUO_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rt >= w_trial);
    assign w_sub   = w_rt - w_trial;

    assign w_scaled = {{(onnd_pkg::OUT_W-onnd_pkg::ROOT_W){1'b0}}, r_root};
    assign w_cur    = r_min[r_oct];

    assign o_stat.pass     = r_pass;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= onnd_pkg::RADIUS_RST;
            r_min_hits  <= onnd_pkg::MIN_HITS_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < onnd_pkg::NUM_OCT; i++) begin
                r_min[i] <= onnd_pkg::FAR_VAL;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    onnd_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[onnd_pkg::RAD_W-1:0];
                    onnd_pkg::CFG_MIN_HITS: r_min_hits <= i_cfg_data[onnd_pkg::HITS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < onnd_pkg::NUM_OCT; i++) begin
                    r_min[i] <= onnd_pkg::FAR_VAL;
                end
            end else begin
                if (m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                if (i_cmd.upd && (w_scaled < w_cur)) begin
                    r_min[r_oct] <= w_scaled;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int i = 0; i < onnd_pkg::NUM_OCT; i++) begin
                m_axis_tdata[i*onnd_pkg::OUT_W +: onnd_pkg::OUT_W] <= r_min[i];
            end
        end
        if (i_cmd.load) begin
            r_ref_x    <= s_axis_tdata[0*PW +: PW];
            r_ref_y    <= s_axis_tdata[1*PW +: PW];
            r_oth_x    <= s_axis_tdata[2*PW +: PW];
            r_oth_y    <= s_axis_tdata[3*PW +: PW];
            r_consider <= !s_axis_tuser
                       && (s_axis_tdata[4*PW +: onnd_pkg::HITS_W] >= r_min_hits);
            r_last     <= s_axis_tlast;
        end
        if (i_cmd.diff) begin
            r_sx <= w_dx[DW-1];
            r_sy <= w_dy[DW-1];
            r_ax <= w_dx[DW-1] ? PW'(-w_dx) : w_dx[PW-1:0];
            r_ay <= w_dy[DW-1] ? PW'(-w_dy) : w_dy[PW-1:0];
        end
        if (i_cmd.mul) begin
            r_sqx    <= {{PW{1'b0}}, r_ax} * {{PW{1'b0}}, r_ax};
            r_sqy    <= {{PW{1'b0}}, r_ay} * {{PW{1'b0}}, r_ay};
            r_r2     <= {{onnd_pkg::RAD_W{1'b0}}, r_radius} * {{onnd_pkg::RAD_W{1'b0}}, r_radius};
            r_oct_ok <= (r_ax != '0) && (r_ay != '0) && (r_ax != r_ay);
            r_oct    <= w_oct;
        end
        if (i_cmd.sum) begin
            r_sum  <= w_sum;
            r_pass <= r_consider && r_oct_ok && (w_sum < {1'b0, r_r2});
        end
        if (i_cmd.div_init) begin
            // 9 * sum
            r_num  <= {1'b0, r_sum[onnd_pkg::SUM_W-2:0], 3'b000}
                    + {4'b0000, r_sum[onnd_pkg::SUM_W-2:0]};
            r_rem  <= '0;
            r_quo  <= '0;
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[onnd_pkg::NUM_W-5:0], 4'b0000};
            r_rem <= w_dr[onnd_pkg::DIV_REM_W-1:0];
            r_quo <= {r_quo[onnd_pkg::QUO_W-5:0], w_qd};
        end
        if (i_cmd.sqrt_step) begin
            r_quo <= {r_quo[onnd_pkg::QUO_W-3:0], 2'b00};
            if (w_ge) begin
                r_srem <= w_sub[onnd_pkg::SREM_W-1:0];
                r_root <= {r_root[onnd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_srem <= w_rt[onnd_pkg::SREM_W-1:0];
                r_root <= {r_root[onnd_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: src/octant_nearest_neighbor_distance.sv
`timescale 1ns / 1ps
// one request at a time: a counted candidate goes through diff, mul and sum, then 13
// divide-by-100 nibble steps, 23 square-root steps and an update; a skipped one skips those
// on a last request the result turns valid at the same edge at which ready returns
// the output register lets the next request in while a result waits; a later last
// request holds off ready until that result is taken
// synchronous active-low reset: registers to defaults, all octant minimums to one million m
module octant_nearest_neighbor_distance (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [onnd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [onnd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // ref_x, ref_y, other_x, other_y, hit_count
    input  logic [onnd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // is_self
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dist_octant1 .. dist_octant8
    output logic [onnd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    onnd_pkg::t_cmd  w_cmd;
    onnd_pkg::t_stat w_stat;

    onnd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    onnd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

endmodule

FILE: bench/octant_nearest_neighbor_distance_test.sv
`timescale 1ns / 1ps
module octant_nearest_neighbor_distance_test;

    import onnd_pkg::*;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 6;
    localparam int  SETTLE_CYCLES = 64;
    localparam int  CYCLE_LIMIT   = 1500000;
    localparam int  LONG_HOLD     = 3000;
    localparam int  PHASE_ITEMS   = 270;
    localparam int  NO_OCTANT     = -1;
    localparam logic [RAD_W-1:0] RADIUS_MAX = '1;

    typedef struct packed {
        logic signed [POS_W-1:0] ref_x;
        logic signed [POS_W-1:0] ref_y;
        logic signed [POS_W-1:0] other_x;
        logic signed [POS_W-1:0] other_y;
        logic [HITS_W-1:0]       hits;
        logic                    is_self;
        logic                    last;
    } candidate_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    octant_nearest_neighbor_distance i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    candidate_t              pending_candidates[$];
    logic [OUT_DATA_W-1:0]   expected_minimums[$];
    candidate_t              offered_req = '0;
    logic [OUT_W-1:0]        octant_best [NUM_OCT];
    logic [RAD_W-1:0]        cfg_radius = RADIUS_RST;
    logic [HITS_W-1:0]       cfg_min_hits = MIN_HITS_RST;
    logic                    req_taken = 1'b0;
    logic                    steady_mode = 1'b0;
    logic                    long_hold_request = 1'b0;
    logic                    long_hold_done = 1'b0;
    int                      send_gap = 0;
    int                      recv_stall = 0;
    int                      stall_pick;
    int                      mismatch_count = 0;
    int                      cycle_count = 0;

    function automatic int pick_gap(logic steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned value);
        longint unsigned rest, root, probe;
        rest  = value;
        root  = 0;
        probe = 64'h1 << 62;
        while (probe > value)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic int octant_index(longint dx, longint dy,
                                        longint unsigned ax, longint unsigned ay);
        if (dx == 0 || dy == 0 || ax == ay)
            return NO_OCTANT;
        if (dx > 0 && dy > 0)
            return (ax < ay) ? 0 : 1;
        if (dx > 0)
            return (ax > ay) ? 2 : 3;
        if (dy < 0)
            return (ax < ay) ? 4 : 5;
        return (ax > ay) ? 6 : 7;
    endfunction

    function automatic void clear_octants();
        for (int k = 0; k < NUM_OCT; k++)
            octant_best[k] = FAR_VAL;
    endfunction

    function automatic void track_candidate(candidate_t c);
        longint            dx, dy;
        longint unsigned   ax, ay, dist_sq, radius_sq, scaled;
        int                oct;
        logic [OUT_DATA_W-1:0] minimums;
        if (!c.is_self && c.hits >= cfg_min_hits) begin
            dx = longint'(c.other_x) - longint'(c.ref_x);
            dy = longint'(c.other_y) - longint'(c.ref_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            dist_sq   = ax * ax + ay * ay;
            radius_sq = 64'(cfg_radius) * 64'(cfg_radius);
            oct = octant_index(dx, dy, ax, ay);
            if (dist_sq < radius_sq && oct != NO_OCTANT) begin
                scaled = int_sqrt((dist_sq * 9) / 100) & 64'hFFFFFFF;
                if (scaled < 64'(octant_best[oct]))
                    octant_best[oct] = OUT_W'(scaled);
            end
        end
        if (c.last) begin
            for (int k = 0; k < NUM_OCT; k++)
                minimums[k*OUT_W +: OUT_W] = octant_best[k];
            expected_minimums.push_back(minimums);
            clear_octants();
        end
    endfunction

    function automatic candidate_t make_cand(int rx, int ry, int ox, int oy, int hits,
                                             logic self, logic last);
        candidate_t c;
        c.ref_x   = POS_W'(rx);
        c.ref_y   = POS_W'(ry);
        c.other_x = POS_W'(ox);
        c.other_y = POS_W'(oy);
        c.hits    = HITS_W'(hits);
        c.is_self = self;
        c.last    = last;
        return c;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_candidates.size() > 0) begin
                offered_req   <= pending_candidates[0];
                s_axis_tdata  <= {pending_candidates[0].hits, pending_candidates[0].other_y,
                                  pending_candidates[0].other_x, pending_candidates[0].ref_y,
                                  pending_candidates[0].ref_x};
                s_axis_tuser  <= pending_candidates[0].is_self;
                s_axis_tlast  <= pending_candidates[0].last;
                s_axis_tvalid <= 1'b1;
                send_gap      <= pick_gap(steady_mode);
                void'(pending_candidates.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_request && !long_hold_done) begin
            long_hold_done <= 1'b1;
            recv_stall     <= LONG_HOLD;
            m_axis_tready  <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall    <= recv_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            stall_pick = pick_gap(steady_mode);
            if (stall_pick == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                recv_stall    <= stall_pick - 1;
            end
        end
    end

    // request prediction and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_octants();
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_minimums.size() == 0) begin
                    $display("%0t: result with none expected, expected none actual %h",
                             $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    for (int k = 0; k < NUM_OCT; k++) begin
                        if (m_axis_tdata[k*OUT_W +: OUT_W] !==
                            expected_minimums[0][k*OUT_W +: OUT_W]) begin
                            $display("%0t: dist_octant%0d expected %0d actual %0d", $time, k + 1,
                                     expected_minimums[0][k*OUT_W +: OUT_W],
                                     m_axis_tdata[k*OUT_W +: OUT_W]);
                            mismatch_count++;
                        end
                    end
                    void'(expected_minimums.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                track_candidate(offered_req);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_RADIUS)
            cfg_radius = value;
        else
            cfg_min_hits = value[HITS_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_search(logic [RAD_W-1:0] radius, logic [HITS_W-1:0] hits_floor);
        write_reg(CFG_RADIUS, radius);
        // upper bits of the min-hits write are junk and must be dropped
        write_reg(CFG_MIN_HITS, {16'($urandom), hits_floor});
    endtask

    task automatic wait_idle();
        while (pending_candidates.size() != 0 || s_axis_tvalid || expected_minimums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_random_lists(int count);
        int         added, len, span, dx, dy, roll;
        candidate_t c;
        added = 0;
        span  = (cfg_radius == 0) ? 1024 : int'(cfg_radius);
        while (added < count) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
            c.ref_x = POS_W'($urandom);
            c.ref_y = POS_W'($urandom);
            for (int j = 0; j < len; j++) begin
                roll = $urandom_range(0, 99);
                dx = int'($urandom_range(0, 2 * span)) - span;
                dy = int'($urandom_range(0, 2 * span)) - span;
                if (roll < 10)
                    dy = roll[0] ? dx : -dx;
                else if (roll < 13)
                    dx = 0;
                else if (roll < 16)
                    dy = 0;
                c.other_x = POS_W'(c.ref_x + dx);
                c.other_y = POS_W'(c.ref_y + dy);
                if (roll >= 16 && roll < 30) begin
                    c.other_x = POS_W'($urandom);
                    c.other_y = POS_W'($urandom);
                end
                if ($urandom_range(0, 99) < 12)
                    c.hits = HITS_W'($urandom_range(0, 255));
                else
                    c.hits = HITS_W'($urandom_range(int'(cfg_min_hits), 255));
                c.is_self = ($urandom_range(0, 24) == 0);
                c.last    = (j == len - 1);
                pending_candidates.push_back(c);
            end
            added += len;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every octant, ties, axes, zero offset, skips, on and inside the radius
        pending_candidates.push_back(make_cand(1000, -2000, 1100, -1700, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1300, -1900, 200, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1300, -2100, 255, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1100, -2300, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 900, -2300, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 700, -2100, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 700, -1900, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1010, -1980, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1050, -1400, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1200, -1800, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1000, -1950, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1050, -2000, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 1000, -2000, 3, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 999, -1998, 3, 1, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 998, -1997, 2, 0, 0));
        pending_candidates.push_back(make_cand(1000, -2000, 900, -1700, 3, 0, 1));
        pending_candidates.push_back(make_cand(0, 0, 1536, 2048, 9, 0, 0));
        pending_candidates.push_back(make_cand(0, 0, -1535, 2048, 9, 0, 0));
        pending_candidates.push_back(make_cand(0, 0, 1, 2, 9, 1, 1));
        pending_candidates.push_back(make_cand(5, 5, 6, 7, 0, 0, 1));
        wait_idle();

        // largest radius, extreme coordinates
        set_search(RADIUS_MAX, 8'd0);
        pending_candidates.push_back(make_cand(-8388608, 0, 8388606, 1, 0, 0, 0));
        pending_candidates.push_back(make_cand(8388607, 8388607, -8388608, -8388608, 0, 0, 0));
        pending_candidates.push_back(make_cand(8388607, -8388608, -8388607, -8388607, 0, 0, 1));
        wait_idle();

        // zero radius, then the highest hit floor
        set_search('0, 8'd255);
        pending_candidates.push_back(make_cand(0, 0, 1, 2, 255, 0, 1));
        wait_idle();
        set_search(RADIUS_RST, 8'd255);
        pending_candidates.push_back(make_cand(0, 0, 1, 2, 255, 0, 0));
        pending_candidates.push_back(make_cand(0, 0, 3, 1, 254, 0, 1));
        wait_idle();

        set_search(RADIUS_RST, MIN_HITS_RST);
        long_hold_request <= 1'b1;
        add_random_lists(PHASE_ITEMS);
        wait_idle();

        set_search(RADIUS_MAX, 8'd0);
        steady_mode <= 1'b1;
        add_random_lists(PHASE_ITEMS);
        wait_idle();
        steady_mode <= 1'b0;

        set_search('0, HITS_W'($urandom));
        add_random_lists(PHASE_ITEMS);
        wait_idle();

        set_search(RAD_W'($urandom), HITS_W'($urandom_range(0, 40)));
        add_random_lists(PHASE_ITEMS);
        wait_idle();

        set_search(RAD_W'($urandom_range(1, 4096)), 8'd255);
        add_random_lists(PHASE_ITEMS);
        wait_idle();

        set_search(24'd1, 8'd0);
        add_random_lists(PHASE_ITEMS / 2);
        wait_idle();

        set_search(RAD_W'($urandom_range(256, 65535)), HITS_W'($urandom_range(0, 10)));
        add_random_lists(PHASE_ITEMS / 2);
        wait_idle();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
src/onnd_pkg.sv
src/onnd_ctrl.sv
src/onnd_dpath.sv
src/octant_nearest_neighbor_distance.sv
bench/octant_nearest_neighbor_distance_test.sv
